// ===== hw/rtl/mjd_pkg.sv =====
`timescale 1ns / 1ps
package mjd_pkg;

   // Width of length counters and the decimal accumulator
   localparam int LEN_W = 24;
   localparam int LINE_POS_MAX = 31;
   localparam int LEN_NUMBER_START = 15;
   localparam logic [9:0] STATUS_MAX = 10'd999;
   localparam logic [LEN_W-1:0] FRAME_BYTES_RESET = LEN_W'(65536);

   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_RESTART = 1'b1;

   localparam logic [1:0] PHASE_HEAD = 2'd0;
   localparam logic [1:0] PHASE_BOUNDARY = 2'd1;
   localparam logic [1:0] PHASE_PART_HDR = 2'd2;
   localparam logic [1:0] PHASE_DATA = 2'd3;

   localparam logic [1:0] NUM_IDLE = 2'd0;
   localparam logic [1:0] NUM_BLANKS = 2'd1;
   localparam logic [1:0] NUM_DIGITS = 2'd2;
   localparam logic [1:0] NUM_DONE = 2'd3;

   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_LF = 8'h0A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_PLUS = 8'h2B;
   localparam logic [7:0] CHAR_DASH = 8'h2D;

   // Classified byte passed from the front to the back
   typedef struct packed {
      logic       op;
      logic [7:0] byte_value;
      logic       is_cr;
      logic       is_lf;
      logic       is_space;
      logic       is_blank;
      logic       is_plus;
      logic       is_digit;
   } item_type;

   // "HTTP/" by position
   function automatic logic [7:0] http_char(input logic [2:0] pos);
      logic [7:0] ch;
      case (pos)
         3'd0: ch = 8'h48;
         3'd1: ch = 8'h54;
         3'd2: ch = 8'h54;
         3'd3: ch = 8'h50;
         3'd4: ch = 8'h2F;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   // "Content-Length:" by position
   function automatic logic [7:0] length_char(input logic [3:0] pos);
      logic [7:0] ch;
      case (pos)
         4'd0: ch = 8'h43;
         4'd1: ch = 8'h6F;
         4'd2: ch = 8'h6E;
         4'd3: ch = 8'h74;
         4'd4: ch = 8'h65;
         4'd5: ch = 8'h6E;
         4'd6: ch = 8'h74;
         4'd7: ch = 8'h2D;
         4'd8: ch = 8'h4C;
         4'd9: ch = 8'h65;
         4'd10: ch = 8'h6E;
         4'd11: ch = 8'h67;
         4'd12: ch = 8'h74;
         4'd13: ch = 8'h68;
         4'd14: ch = 8'h3A;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

// ===== hw/rtl/mjd_req_if.sv =====
`timescale 1ns / 1ps
interface mjd_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] byte_value;

   modport source (output valid, output op, output byte_value, input ready);
   modport sink (input valid, input op, input byte_value, output ready);
endinterface

// ===== hw/rtl/mjd_rsp_if.sv =====
`timescale 1ns / 1ps
interface mjd_rsp_if;
   logic        valid;
   logic        ready;
   logic        payload_valid;
   logic [7:0]  payload_byte;
   logic        frame_done;
   logic [23:0] frame_length;
   logic [9:0]  http_status;
   logic [1:0]  parse_phase;
   logic [31:0] frame_total;

   modport source (output valid, output payload_valid, output payload_byte,
      output frame_done, output frame_length, output http_status,
      output parse_phase, output frame_total, input ready);
   modport sink (input valid, input payload_valid, input payload_byte,
      input frame_done, input frame_length, input http_status,
      input parse_phase, input frame_total, output ready);
endinterface

// ===== hw/rtl/mjpeg_multipart_deframer.sv =====
`timescale 1ns / 1ps
// Multipart MJPEG deframer: one received byte per transaction, one result per
// transaction. A new byte is taken every clock cycle as long as results are taken;
// the back end updates the parser state as it pops each byte, so sustained rate is
// one byte per cycle. An accepted byte is written into the queue, moves into the
// output register once that register is free or being drained, and its result is
// presented from there. A two-entry queue between classification and execution
// lets either side stall alone.
module mjpeg_multipart_deframer
   import mjd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [LEN_W-1:0] csr_wdata,
   mjd_req_if.sink          req_chan,
   mjd_rsp_if.source        rsp_chan
);

   logic     q_full;
   logic     q_push;
   logic     q_pop;
   logic     q_not_empty;
   item_type q_item;
   item_type q_head;

   mjd_front u_front (
      .req_chan (req_chan),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_item   (q_item)
   );

   mjd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_item),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   mjd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .q_not_empty (q_not_empty),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .rsp_chan    (rsp_chan)
   );

endmodule

// ===== hw/rtl/mjd_front.sv =====
`timescale 1ns / 1ps
module mjd_front
   import mjd_pkg::*;
(
   mjd_req_if.sink  req_chan,
   input  logic     q_full,
   output logic     q_push,
   output item_type q_item
);

   // Accept whenever the queue has room
   assign req_chan.ready = !q_full;
   assign q_push = req_chan.valid && !q_full;

   // Classify the byte
   always_comb begin
      q_item.op = req_chan.op;
      q_item.byte_value = req_chan.byte_value;
      q_item.is_cr = (req_chan.byte_value == CHAR_CR);
      q_item.is_lf = (req_chan.byte_value == CHAR_LF);
      q_item.is_space = (req_chan.byte_value == CHAR_SPACE);
      q_item.is_blank = (req_chan.byte_value == CHAR_SPACE) ||
         (req_chan.byte_value == 8'h09) || (req_chan.byte_value == 8'h0B) ||
         (req_chan.byte_value == 8'h0C);
      q_item.is_plus = (req_chan.byte_value == CHAR_PLUS);
      q_item.is_digit = (req_chan.byte_value >= 8'h30) && (req_chan.byte_value <= 8'h39);
   end

endmodule

// ===== hw/rtl/mjd_queue.sv =====
`timescale 1ns / 1ps
module mjd_queue
   import mjd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   input  logic     pop,
   output logic     full,
   output logic     not_empty,
   output item_type head
);

   item_type   mem [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head = mem[rd_ptr_ff];

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // Store the entry
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== hw/rtl/mjd_back.sv =====
`timescale 1ns / 1ps
module mjd_back
   import mjd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [LEN_W-1:0]  csr_wdata,
   input  logic              q_not_empty,
   input  item_type          q_head,
   output logic              q_pop,
   mjd_rsp_if.source         rsp_chan
);

   logic [LEN_W-1:0] max_bytes_ff;
   logic [1:0]       phase_ff, phase_in;
   logic [4:0]       line_pos_ff, line_pos_in;
   logic             nonempty_ff, nonempty_in;
   logic             http_ok_ff, http_ok_in;
   logic             dash_ok_ff, dash_ok_in;
   logic             len_ok_ff, len_ok_in;
   logic [1:0]       num_ff, num_in;
   logic [LEN_W-1:0] acc_ff, acc_in;
   logic [9:0]       status_ff, status_in;
   logic [LEN_W-1:0] clen_ff, clen_in;
   logic [LEN_W-1:0] counted_ff, counted_in;
   logic [31:0]      frames_ff, frames_in;

   logic             out_valid_ff;
   logic             pv_ff, pv_in;
   logic [7:0]       pb_ff, pb_in;
   logic             done_ff, done_in;
   logic [LEN_W-1:0] flen_ff, flen_in;

   logic [LEN_W+3:0] acc_next;
   logic             clear_line;

   // Pop when the output register is free or being drained
   assign q_pop = q_not_empty && (!out_valid_ff || rsp_chan.ready);

   assign acc_next = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0} +
      {(LEN_W)'(0), q_head.byte_value[3:0]};

   // Execute one classified byte
   always_comb begin
      phase_in = phase_ff;
      line_pos_in = line_pos_ff;
      nonempty_in = nonempty_ff;
      http_ok_in = http_ok_ff;
      dash_ok_in = dash_ok_ff;
      len_ok_in = len_ok_ff;
      num_in = num_ff;
      acc_in = acc_ff;
      status_in = status_ff;
      clen_in = clen_ff;
      counted_in = counted_ff;
      frames_in = frames_ff;
      pv_in = 1'b0;
      pb_in = 8'h00;
      done_in = 1'b0;
      flen_in = '0;
      clear_line = 1'b0;
      if (q_head.op == OP_RESTART) begin
         phase_in = PHASE_HEAD;
         clear_line = 1'b1;
         status_in = '0;
         clen_in = '0;
         counted_in = '0;
      end else if (phase_ff == PHASE_DATA) begin
         if (counted_ff < max_bytes_ff) begin
            pv_in = 1'b1;
            pb_in = q_head.byte_value;
         end
         if (counted_ff < clen_ff) begin
            counted_in = counted_ff + 1'b1;
         end
         if (counted_in >= clen_ff) begin
            done_in = 1'b1;
            flen_in = (clen_ff < max_bytes_ff) ? clen_ff : max_bytes_ff;
            frames_in = frames_ff + 1'b1;
            phase_in = PHASE_BOUNDARY;
            clear_line = 1'b1;
         end
      end else if (q_head.is_cr) begin
         // drop carriage returns
      end else if (q_head.is_lf) begin
         case (phase_ff)
            PHASE_HEAD: begin
               if (http_ok_ff && line_pos_ff >= 5'd5 && num_ff != NUM_IDLE) begin
                  status_in = (acc_ff > LEN_W'(STATUS_MAX)) ? STATUS_MAX : acc_ff[9:0];
               end
               if (!nonempty_ff) begin
                  phase_in = PHASE_BOUNDARY;
               end
            end
            PHASE_BOUNDARY: begin
               if (dash_ok_ff && line_pos_ff >= 5'd2) begin
                  phase_in = PHASE_PART_HDR;
               end
            end
            PHASE_PART_HDR: begin
               if (len_ok_ff && line_pos_ff >= 5'(LEN_NUMBER_START)) begin
                  clen_in = acc_ff;
               end
               if (!nonempty_ff && clen_in != '0) begin
                  phase_in = PHASE_DATA;
                  counted_in = '0;
               end
            end
            default: begin
            end
         endcase
         clear_line = 1'b1;
      end else begin
         // Prefix matching
         if (line_pos_ff < 5'd5 && q_head.byte_value != http_char(line_pos_ff[2:0])) begin
            http_ok_in = 1'b0;
         end
         if (line_pos_ff < 5'd2 &&
             q_head.byte_value != (line_pos_ff[0] ? CHAR_DASH : CHAR_DASH)) begin
            dash_ok_in = 1'b0;
         end
         if (line_pos_ff < 5'(LEN_NUMBER_START) &&
             q_head.byte_value != length_char(line_pos_ff[3:0])) begin
            len_ok_in = 1'b0;
         end
         // Decimal number
         if (num_ff == NUM_IDLE) begin
            if (phase_ff == PHASE_HEAD && q_head.is_space) begin
               num_in = NUM_BLANKS;
            end
         end else if (num_ff == NUM_BLANKS && q_head.is_blank) begin
            num_in = NUM_BLANKS;
         end else if (num_ff == NUM_BLANKS && q_head.is_plus) begin
            num_in = NUM_DIGITS;
         end else if (num_ff == NUM_BLANKS || num_ff == NUM_DIGITS) begin
            if (q_head.is_digit) begin
               acc_in = (acc_next[LEN_W+3:LEN_W] != 4'd0) ? '1 : acc_next[LEN_W-1:0];
               num_in = NUM_DIGITS;
            end else begin
               num_in = NUM_DONE;
            end
         end
         if (line_pos_ff != 5'(LINE_POS_MAX)) begin
            line_pos_in = line_pos_ff + 5'd1;
         end
         nonempty_in = 1'b1;
         if (phase_ff == PHASE_PART_HDR && num_in == NUM_IDLE &&
             line_pos_in == 5'(LEN_NUMBER_START)) begin
            num_in = NUM_BLANKS;
         end
      end
      if (clear_line) begin
         line_pos_in = '0;
         nonempty_in = 1'b0;
         http_ok_in = 1'b1;
         dash_ok_in = 1'b1;
         len_ok_in = 1'b1;
         num_in = NUM_IDLE;
         acc_in = '0;
      end
   end

   // Hold parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         max_bytes_ff <= FRAME_BYTES_RESET;
         phase_ff <= PHASE_HEAD;
         line_pos_ff <= '0;
         nonempty_ff <= 1'b0;
         http_ok_ff <= 1'b1;
         dash_ok_ff <= 1'b1;
         len_ok_ff <= 1'b1;
         num_ff <= NUM_IDLE;
         acc_ff <= '0;
         status_ff <= '0;
         clen_ff <= '0;
         counted_ff <= '0;
         frames_ff <= '0;
      end else begin
         if (csr_we) begin
            max_bytes_ff <= csr_wdata;
         end
         if (q_pop) begin
            phase_ff <= phase_in;
            line_pos_ff <= line_pos_in;
            nonempty_ff <= nonempty_in;
            http_ok_ff <= http_ok_in;
            dash_ok_ff <= dash_ok_in;
            len_ok_ff <= len_ok_in;
            num_ff <= num_in;
            acc_ff <= acc_in;
            status_ff <= status_in;
            clen_ff <= clen_in;
            counted_ff <= counted_in;
            frames_ff <= frames_in;
         end
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (q_pop) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         pv_ff <= pv_in;
         pb_ff <= pb_in;
         done_ff <= done_in;
         flen_ff <= flen_in;
      end
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.payload_valid = pv_ff;
   assign rsp_chan.payload_byte = pb_ff;
   assign rsp_chan.frame_done = done_ff;
   assign rsp_chan.frame_length = flen_ff;
   assign rsp_chan.http_status = status_ff;
   assign rsp_chan.parse_phase = phase_ff;
   assign rsp_chan.frame_total = frames_ff;

   // A completed frame leaves the parser waiting for a boundary
   a_done_phase: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && done_ff |-> phase_ff == PHASE_BOUNDARY)
      else $error("frame end without return to boundary wait");

   // Dropped payload carries a zero byte
   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !pv_ff |-> pb_ff == 8'h00)
      else $error("payload byte without payload valid");

   // Frame length appears only with frame end
   a_len_done: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !done_ff |-> flen_ff == '0)
      else $error("frame length outside frame end");

   // Frame count moves only on a completed frame
   a_count: assert property (@(posedge clock) disable iff (reset)
      q_pop && !done_in |=> $stable(frames_ff))
      else $error("frame count moved without frame end");

endmodule

// ===== bench/tb_mjpeg_multipart_deframer.sv =====
`timescale 1ns / 1ps
module tb_mjpeg_multipart_deframer
   import mjd_pkg::*;
();

   localparam int STALL_LIMIT = 5000;
   localparam int ITEM_TARGET = 450;
   localparam int STEADY_ITEMS = 100;

   typedef struct packed {
      logic        payload_valid;
      logic [7:0]  payload_byte;
      logic        frame_done;
      logic [23:0] frame_length;
      logic [9:0]  http_status;
      logic [1:0]  parse_phase;
      logic [31:0] frame_total;
   } deframe_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [LEN_W-1:0] csr_wdata = '0;

   mjd_req_if req_bus ();
   mjd_rsp_if rsp_bus ();

   mjpeg_multipart_deframer dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus)
   );

   always #5 clock = ~clock;

   deframe_result_type expected_results[$];
   int error_count = 0;
   int bytes_sent = 0;
   int quiet_cycles = 0;
   bit idle_enable = 1'b0;
   int stall_left = 0;

   // Parser mirror
   logic [LEN_W-1:0] frame_capacity;
   logic [1:0]       m_phase;
   logic [4:0]       m_line_pos;
   logic             m_line_nonempty;
   logic             m_http_match;
   logic             m_dash_match;
   logic             m_length_match;
   logic [1:0]       m_num_phase;
   logic [LEN_W-1:0] m_number;
   logic [9:0]       m_status;
   logic [LEN_W-1:0] m_content_length;
   logic [LEN_W-1:0] m_bytes_counted;
   logic [31:0]      m_frames;

   string http_text = "HTTP/";
   string length_text = "Content-Length:";

   task automatic report_mismatch(input string field, input longint got, input longint want);
      $display("MISMATCH %s at %0t: got %0d expected %0d", field, $time, got, want);
      error_count++;
   endtask

   function automatic bit is_blank(input logic [7:0] c);
      return c == 8'h20 || c == 8'h09 || c == 8'h0B || c == 8'h0C;
   endfunction

   task automatic clear_line_state();
      m_line_pos = '0;
      m_line_nonempty = 1'b0;
      m_http_match = 1'b1;
      m_dash_match = 1'b1;
      m_length_match = 1'b1;
      m_num_phase = NUM_IDLE;
      m_number = '0;
   endtask

   task automatic restart_mirror();
      m_phase = PHASE_HEAD;
      clear_line_state();
      m_status = '0;
      m_content_length = '0;
      m_bytes_counted = '0;
   endtask

   // Feed one character of a line to the number scanner
   task automatic scan_number_char(input logic [7:0] c);
      logic [63:0] acc;
      if (m_num_phase == NUM_BLANKS && is_blank(c)) return;
      if (m_num_phase == NUM_BLANKS && c == CHAR_PLUS) begin
         m_num_phase = NUM_DIGITS;
         return;
      end
      if (m_num_phase == NUM_BLANKS || m_num_phase == NUM_DIGITS) begin
         if (c >= "0" && c <= "9") begin
            acc = 64'(m_number) * 10 + 64'(c - "0");
            if (acc > 64'hFF_FFFF) acc = 64'hFF_FFFF;
            m_number = acc[LEN_W-1:0];
            m_num_phase = NUM_DIGITS;
         end else begin
            m_num_phase = NUM_DONE;
         end
      end
   endtask

   task automatic line_char(input logic [7:0] c);
      if (m_line_pos < 5 && c != http_text[m_line_pos]) m_http_match = 1'b0;
      if (m_line_pos < 2 && c != "-") m_dash_match = 1'b0;
      if (m_line_pos < 15 && c != length_text[m_line_pos]) m_length_match = 1'b0;
      if (m_num_phase == NUM_IDLE) begin
         if (m_phase == PHASE_HEAD && c == CHAR_SPACE) m_num_phase = NUM_BLANKS;
      end else begin
         scan_number_char(c);
      end
      if (m_line_pos < LINE_POS_MAX) m_line_pos++;
      m_line_nonempty = 1'b1;
      if (m_phase == PHASE_PART_HDR && m_num_phase == NUM_IDLE && m_line_pos == LEN_NUMBER_START)
         m_num_phase = NUM_BLANKS;
   endtask

   task automatic line_end();
      case (m_phase)
         PHASE_HEAD: begin
            if (m_http_match && m_line_pos >= 5 && m_num_phase != NUM_IDLE)
               m_status = (m_number > LEN_W'(STATUS_MAX)) ? STATUS_MAX : m_number[9:0];
            if (!m_line_nonempty) m_phase = PHASE_BOUNDARY;
         end
         PHASE_BOUNDARY: begin
            if (m_dash_match && m_line_pos >= 2) m_phase = PHASE_PART_HDR;
         end
         PHASE_PART_HDR: begin
            if (m_length_match && m_line_pos >= 15) m_content_length = m_number;
            if (!m_line_nonempty && m_content_length != 0) begin
               m_phase = PHASE_DATA;
               m_bytes_counted = '0;
            end
         end
         default: ;
      endcase
      clear_line_state();
   endtask

   // Advance the mirror by one transaction and queue the result it causes
   task automatic predict_deframe(input logic op, input logic [7:0] c);
      deframe_result_type r;
      r = '0;
      if (op == OP_RESTART) begin
         restart_mirror();
      end else if (m_phase == PHASE_DATA) begin
         if (m_bytes_counted < frame_capacity) begin
            r.payload_valid = 1'b1;
            r.payload_byte = c;
         end
         if (m_bytes_counted < m_content_length) m_bytes_counted++;
         if (m_bytes_counted >= m_content_length) begin
            r.frame_done = 1'b1;
            r.frame_length = (m_content_length < frame_capacity) ? m_content_length
                                                                 : frame_capacity;
            m_frames++;
            m_phase = PHASE_BOUNDARY;
            clear_line_state();
         end
      end else if (c == CHAR_CR) begin
      end else if (c == CHAR_LF) begin
         line_end();
      end else begin
         line_char(c);
      end
      r.http_status = m_status;
      r.parse_phase = m_phase;
      r.frame_total = m_frames;
      expected_results.push_back(r);
   endtask

   // Drive one transaction; valid stays high unless a gap is taken
   task automatic send_item(input logic op, input logic [7:0] b);
      if (idle_enable && $urandom_range(0, 5) == 0) begin
         req_bus.valid = 1'b0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.op = op;
      req_bus.byte_value = b;
      do @(posedge clock); while (!req_bus.ready);
      predict_deframe(op, b);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_text(input string s);
      foreach (s[i]) send_item(OP_BYTE, s[i]);
   endtask

   task automatic send_line(input string s);
      send_text(s);
      send_item(OP_BYTE, CHAR_CR);
      send_item(OP_BYTE, CHAR_LF);
   endtask

   task automatic drain_results();
      req_bus.valid = 1'b0;
      while (expected_results.size() != 0) @(negedge clock);
   endtask

   task automatic set_frame_capacity(input logic [LEN_W-1:0] value);
      drain_results();
      repeat (4) @(negedge clock);
      csr_we = 1'b1;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      frame_capacity = value;
   endtask

   // Send payload while the mirror is in data mode; bail out with a restart if too long
   task automatic send_payload(input int max_bytes);
      int n;
      n = 0;
      while (m_phase == PHASE_DATA && n < max_bytes) begin
         send_item(OP_BYTE, 8'($urandom));
         n++;
      end
      if (m_phase == PHASE_DATA) send_item(OP_RESTART, 8'($urandom));
   endtask

   task automatic send_frame(input int len);
      send_line("--myboundary");
      send_line($sformatf("Content-Length: %0d", len));
      send_line("");
      send_payload(64);
   endtask

   task automatic test_head_status();
      send_item(OP_RESTART, 8'hFF);
      send_line("HTTP/1.1 200 OK");
      send_line("HTTP/1.0");
      send_line("HTTP/1.1 \t+404");
      send_line("HTTP/1.1 -7");
      send_line("HTTP/1.1 123456789012");
      send_line("");
      send_frame(2);
   endtask

   task automatic test_part_headers();
      send_line("--b");
      send_line("Content-Length: 0");
      send_line("");
      send_line("Content-Length:3");
      send_line("");
      send_payload(64);
      // no length line: previous length reused
      send_line("--b");
      send_line("Content-Type: image/jpeg");
      send_line("");
      send_payload(64);
   endtask

   task automatic test_capacity_limits();
      set_frame_capacity(LEN_W'(3));
      send_frame(7);
      set_frame_capacity(LEN_W'(1));
      send_frame(4);
      set_frame_capacity(LEN_W'(0));
      send_frame(3);
      set_frame_capacity(24'hFF_FFFF);
      send_frame(5);
      set_frame_capacity(LEN_W'(65536));
   endtask

   task automatic send_random_session();
      int kind;
      int frames;
      int code;
      if ($urandom_range(0, 2) == 0) send_item(OP_RESTART, 8'($urandom));
      kind = $urandom_range(0, 5);
      code = $urandom_range(0, 1200);
      case (kind)
         0: send_line("HTTP/1.0");
         1: send_line($sformatf("HTTP/1.1  +%0d OK", code));
         2: send_line("HTTP/1.1 99999999999");
         default: send_line($sformatf("HTTP/1.1 %0d OK", code));
      endcase
      if ($urandom_range(0, 1)) send_line("Server: cam");
      if ($urandom_range(0, 4) == 0) send_text("\tstray");
      send_line("");
      if ($urandom_range(0, 3) == 0) send_line("noise");
      frames = $urandom_range(1, 3);
      repeat (frames) begin
         if ($urandom_range(0, 5) == 0)
            send_line("-x");
         else
            send_line("--frame");
         if ($urandom_range(0, 1)) send_line("Content-Type: image/jpeg");
         if ($urandom_range(0, 5) != 0)
            send_line($sformatf("Content-Length: %0d", $urandom_range(1, 30)));
         send_line("");
         send_payload(64);
      end
   endtask

   task automatic test_random_stream();
      idle_enable = 1'b1;
      do begin
         if ($urandom_range(0, 3) == 0)
            set_frame_capacity(LEN_W'($urandom_range(1, 40)));
         send_random_session();
         // let every result return before continuing
         if ($urandom_range(0, 4) == 0) drain_results();
      end while (bytes_sent < ITEM_TARGET - STEADY_ITEMS);
      drain_results();
      idle_enable = 1'b0;
   endtask

   task automatic test_steady_rate();
      set_frame_capacity(LEN_W'(16));
      do send_random_session(); while (bytes_sent < ITEM_TARGET);
   endtask

   // Result receiver with random backpressure
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_bus.ready = 1'b0;
         stall_left--;
      end else if (idle_enable && $urandom_range(0, 7) == 0) begin
         rsp_bus.ready = 1'b0;
         stall_left = $urandom_range(0, 10);
      end else begin
         rsp_bus.ready = 1'b1;
      end
   end

   // Compare each result transaction with the oldest expectation
   always @(posedge clock) begin
      deframe_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected result", 1, 0);
         end else begin
            want = expected_results.pop_front();
            if (rsp_bus.payload_valid !== want.payload_valid)
               report_mismatch("payload_valid", rsp_bus.payload_valid, want.payload_valid);
            if (rsp_bus.payload_byte !== want.payload_byte)
               report_mismatch("payload_byte", rsp_bus.payload_byte, want.payload_byte);
            if (rsp_bus.frame_done !== want.frame_done)
               report_mismatch("frame_done", rsp_bus.frame_done, want.frame_done);
            if (rsp_bus.frame_length !== want.frame_length)
               report_mismatch("frame_length", rsp_bus.frame_length, want.frame_length);
            if (rsp_bus.http_status !== want.http_status)
               report_mismatch("http_status", rsp_bus.http_status, want.http_status);
            if (rsp_bus.parse_phase !== want.parse_phase)
               report_mismatch("parse_phase", rsp_bus.parse_phase, want.parse_phase);
            if (rsp_bus.frame_total !== want.frame_total)
               report_mismatch("frame_total", rsp_bus.frame_total, want.frame_total);
         end
      end
   end

   // Watchdog: end the run when no transaction moves for too long
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("mjpeg_multipart_deframer verification failed");
         $finish;
      end
   end

   initial begin
      req_bus.valid = 1'b0;
      req_bus.op = OP_BYTE;
      req_bus.byte_value = '0;
      rsp_bus.ready = 1'b1;
      frame_capacity = FRAME_BYTES_RESET;
      m_frames = '0;
      restart_mirror();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_head_status();
      test_part_headers();
      test_capacity_limits();
      test_random_stream();
      test_steady_rate();

      drain_results();
      repeat (10) @(posedge clock);
      if (error_count == 0)
         $display("mjpeg_multipart_deframer verification clean");
      else
         $display("mjpeg_multipart_deframer verification failed");
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/mjd_pkg.sv
hw/rtl/mjd_req_if.sv
hw/rtl/mjd_rsp_if.sv
hw/rtl/mjd_front.sv
hw/rtl/mjd_queue.sv
hw/rtl/mjd_back.sv
hw/rtl/mjpeg_multipart_deframer.sv
bench/tb_mjpeg_multipart_deframer.sv
